FILE: design/cpu6502_alu_branch_execute_top_defines.svh
// Assertion macros shared by the execute block's checker.
// Depends on nothing; each file that asserts includes it by name.
`ifndef CPU6502_ALU_BRANCH_EXECUTE_TOP_DEFINES_SVH
`define CPU6502_ALU_BRANCH_EXECUTE_TOP_DEFINES_SVH

// Same-cycle implication, clocked on aclk, quiet during reset
`define C65AB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, quiet during reset
`define C65AB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/c65ab_pkg.sv
// Shared types, opcode and mode codes, flag positions and beat packing
// for the 6502 ALU/branch execute block. No dependencies.
package c65ab_pkg;

    // Instruction codes
    localparam logic [3:0] FN_ADC = 4'd0;
    localparam logic [3:0] FN_AND = 4'd1;
    localparam logic [3:0] FN_ASL = 4'd2;
    localparam logic [3:0] FN_BIT = 4'd3;
    localparam logic [3:0] FN_BCC = 4'd4;
    localparam logic [3:0] FN_BCS = 4'd5;
    localparam logic [3:0] FN_BEQ = 4'd6;
    localparam logic [3:0] FN_BMI = 4'd7;
    localparam logic [3:0] FN_BNE = 4'd8;
    localparam logic [3:0] FN_BPL = 4'd9;
    localparam logic [3:0] FN_BVC = 4'd10;
    localparam logic [3:0] FN_BVS = 4'd11;
    localparam logic [3:0] FN_BRK = 4'd12;

    // Addressing modes
    localparam logic [3:0] MD_IMM  = 4'd0;
    localparam logic [3:0] MD_ZP   = 4'd1;
    localparam logic [3:0] MD_ZPX  = 4'd2;
    localparam logic [3:0] MD_ABS  = 4'd3;
    localparam logic [3:0] MD_ABSX = 4'd4;
    localparam logic [3:0] MD_ABSY = 4'd5;
    localparam logic [3:0] MD_INDX = 4'd6;
    localparam logic [3:0] MD_INDY = 4'd7;
    localparam logic [3:0] MD_ACC  = 4'd8;
    localparam logic [3:0] MD_REL  = 4'd9;
    localparam logic [3:0] MD_IMPL = 4'd10;

    // Status bit positions (NV-BDIZC)
    localparam logic [2:0] FB_C = 3'd0;
    localparam logic [2:0] FB_Z = 3'd1;
    localparam logic [2:0] FB_I = 3'd2;
    localparam logic [2:0] FB_B = 3'd4;
    localparam logic [2:0] FB_V = 3'd6;
    localparam logic [2:0] FB_N = 3'd7;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_VEC = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BREAK_VEC = 1'b1;

    // Stack page and the BRK push sequence
    localparam logic [7:0] STACK_PAGE = 8'h01;
    localparam logic [1:0] BEAT_LAST  = 2'd2;
    localparam logic [7:0] BRK_SP_DEC = 8'd3;

    // Channel widths
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 8;
    localparam int M_TDATA_W = 64;

    // Result beat bit positions in m_tdata
    localparam int OUT_CYC_LO   = 32;
    localparam int OUT_CYC_HI   = 34;
    localparam int OUT_WV_BIT   = 35;
    localparam int OUT_ILL_BIT  = 60;

    // Work classes decided by the front end
    typedef enum logic [2:0] {
        K_ADC     = 3'd0,
        K_AND     = 3'd1,
        K_ASL_A   = 3'd2,
        K_ASL_M   = 3'd3,
        K_BIT     = 3'd4,
        K_BRANCH  = 3'd5,
        K_BRK     = 3'd6,
        K_ILLEGAL = 3'd7
    } kind_t;

    // One decoded instruction held in the queue
    typedef struct packed {
        kind_t       kind;
        logic [1:0]  len;
        logic [2:0]  cycles;
        logic [7:0]  operand;
        logic [15:0] wr_addr;
        logic [2:0]  flag_sel;
        logic        want_set;
    } q_entry_t;

    // One result beat
    typedef struct packed {
        logic [7:0]  reg_a;
        logic [7:0]  status;
        logic [15:0] prog_counter;
        logic [2:0]  cycle_count;
        logic        write_valid;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic        illegal;
        logic        last;
    } res_t;

    // Base cycles of the read modes (ADC, AND)
    function automatic logic [2:0] rd_cycles(input logic [3:0] mode);
        logic [2:0] c;
        case (mode)
            MD_IMM:  c = 3'd2;
            MD_ZP:   c = 3'd3;
            MD_ZPX:  c = 3'd4;
            MD_ABS:  c = 3'd4;
            MD_ABSX: c = 3'd4;
            MD_ABSY: c = 3'd4;
            MD_INDX: c = 3'd6;
            MD_INDY: c = 3'd5;
            default: c = 3'd0;
        endcase
        return c;
    endfunction

endpackage

FILE: design/c65ab_front.sv
// Front end: takes input beats, checks the func/mode pair and works out
// length, cycles, page penalty and write-back address. Uses c65ab_pkg.
module c65ab_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [c65ab_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [c65ab_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                          q_full,
    output logic                          q_wr,
    output c65ab_pkg::q_entry_t           q_wdata
);
    import c65ab_pkg::*;

    logic [3:0]  func;
    logic [3:0]  mode;
    logic [7:0]  operand;
    logic [15:0] base;
    logic [7:0]  idx;
    logic [15:0] ix_addr;
    logic        pen;

    assign func    = s_tuser[3:0];
    assign mode    = s_tuser[7:4];
    assign operand = s_tdata[7:0];
    assign base    = s_tdata[23:8];
    assign idx     = s_tdata[31:24];

    // Indexed address and page-cross check
    assign ix_addr = base + {8'h00, idx};
    assign pen     = (base[15:8] != ix_addr[15:8]);

    assign s_tready = !q_full;
    assign q_wr     = s_tvalid && !q_full;

    // Classify
    always_comb begin
        q_wdata          = '0;
        q_wdata.kind     = K_ILLEGAL;
        q_wdata.operand  = operand;
        if (mode inside {MD_ACC, MD_IMPL}) begin
            q_wdata.len = 2'd1;
        end else if (mode inside {MD_ABS, MD_ABSX, MD_ABSY}) begin
            q_wdata.len = 2'd3;
        end else begin
            q_wdata.len = 2'd2;
        end

        case (func)
            FN_ADC, FN_AND: begin
                if (mode inside {[MD_IMM:MD_INDY]}) begin
                    q_wdata.kind   = (func == FN_ADC) ? K_ADC : K_AND;
                    q_wdata.cycles = rd_cycles(mode)
                        + {2'b00, pen && (mode inside {MD_ABSX, MD_ABSY, MD_INDY})};
                end
            end
            FN_ASL: begin
                case (mode)
                    MD_ACC: begin
                        q_wdata.kind   = K_ASL_A;
                        q_wdata.cycles = 3'd2;
                    end
                    MD_ZP: begin
                        q_wdata.kind    = K_ASL_M;
                        q_wdata.cycles  = 3'd5;
                        q_wdata.wr_addr = {8'h00, base[7:0]};
                    end
                    MD_ZPX: begin
                        q_wdata.kind    = K_ASL_M;
                        q_wdata.cycles  = 3'd6;
                        q_wdata.wr_addr = {8'h00, ix_addr[7:0]};
                    end
                    MD_ABS: begin
                        q_wdata.kind    = K_ASL_M;
                        q_wdata.cycles  = 3'd6;
                        q_wdata.wr_addr = base;
                    end
                    MD_ABSX: begin
                        q_wdata.kind    = K_ASL_M;
                        q_wdata.cycles  = 3'd7;
                        q_wdata.wr_addr = ix_addr;
                    end
                    default: ;
                endcase
            end
            FN_BIT: begin
                if (mode == MD_ZP || mode == MD_ABS) begin
                    q_wdata.kind   = K_BIT;
                    q_wdata.cycles = (mode == MD_ZP) ? 3'd3 : 3'd4;
                end
            end
            FN_BCC, FN_BCS, FN_BEQ, FN_BMI, FN_BNE, FN_BPL, FN_BVC, FN_BVS: begin
                if (mode == MD_REL) begin
                    q_wdata.kind     = K_BRANCH;
                    q_wdata.cycles   = 3'd2;
                    q_wdata.want_set = func inside {FN_BCS, FN_BEQ, FN_BMI, FN_BVS};
                    if (func inside {FN_BCC, FN_BCS}) begin
                        q_wdata.flag_sel = FB_C;
                    end else if (func inside {FN_BEQ, FN_BNE}) begin
                        q_wdata.flag_sel = FB_Z;
                    end else if (func inside {FN_BMI, FN_BPL}) begin
                        q_wdata.flag_sel = FB_N;
                    end else begin
                        q_wdata.flag_sel = FB_V;
                    end
                end
            end
            FN_BRK: begin
                if (mode == MD_IMM || mode == MD_IMPL) begin
                    q_wdata.kind   = K_BRK;
                    q_wdata.cycles = 3'd7;
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: design/c65ab_queue.sv
// Small FIFO of decoded instructions between front and back end.
// Uses c65ab_pkg for the entry type.
module c65ab_queue #(
    parameter int DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  c65ab_pkg::q_entry_t wr_data,
    output logic                full,
    input  logic                rd_en,
    output c65ab_pkg::q_entry_t rd_data,
    output logic                empty
);
    import c65ab_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] PTR_MAX  = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    q_entry_t         slot_reg [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: design/c65ab_exec.sv
// Back end: holds A, P, PC, SP and the break vector, executes queued
// instructions and drives the result register. Uses c65ab_pkg.
module c65ab_exec (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_empty,
    input  c65ab_pkg::q_entry_t               q_rdata,
    output logic                              q_rd,
    input  logic                              cfg_wr,
    input  logic [c65ab_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [15:0]                       cfg_wdata,
    output logic                              res_valid,
    input  logic                              res_ready,
    output c65ab_pkg::res_t                   res
);
    import c65ab_pkg::*;

    logic [7:0]  a_reg, a_next;
    logic [7:0]  p_reg, p_next;
    logic [15:0] pc_reg, pc_next;
    logic [7:0]  sp_reg, sp_next;
    logic [15:0] brk_vec_reg;
    logic [1:0]  beat_reg;
    logic        valid_reg;
    res_t        res_reg, res_next;

    q_entry_t    e;
    logic [15:0] pc_adv;
    logic [15:0] tgt;
    logic [8:0]  sum;
    logic [7:0]  r;
    logic        taken;
    logic        final_beat;
    logic        fire;

    assign e      = q_rdata;
    assign fire   = !q_empty && (!valid_reg || res_ready);
    assign q_rd   = fire && final_beat;
    assign res_valid = valid_reg;
    assign res    = res_reg;

    assign pc_adv = pc_reg + {14'd0, e.len};
    assign tgt    = pc_adv + {{8{e.operand[7]}}, e.operand};
    assign sum    = {1'b0, a_reg} + {1'b0, e.operand} + {8'd0, p_reg[FB_C]};
    assign taken  = (p_reg[e.flag_sel] == e.want_set);

    // Execute the head entry
    always_comb begin
        a_next     = a_reg;
        p_next     = p_reg;
        pc_next    = pc_adv;
        sp_next    = sp_reg;
        final_beat = 1'b1;
        r          = '0;
        res_next   = '0;
        res_next.cycle_count = e.cycles;

        case (e.kind)
            K_ADC: begin
                a_next       = sum[7:0];
                p_next[FB_C] = sum[8];
                p_next[FB_V] = (sum[7] ^ a_reg[7]) & (sum[7] ^ e.operand[7]);
                p_next[FB_N] = sum[7];
                p_next[FB_Z] = (sum[7:0] == 8'h00);
            end
            K_AND: begin
                a_next       = a_reg & e.operand;
                p_next[FB_N] = a_next[7];
                p_next[FB_Z] = (a_next == 8'h00);
            end
            K_ASL_A: begin
                a_next       = {a_reg[6:0], 1'b0};
                p_next[FB_C] = a_reg[7];
                p_next[FB_N] = a_reg[6];
                p_next[FB_Z] = (a_reg[6:0] == 7'd0);
            end
            K_ASL_M: begin
                r            = {e.operand[6:0], 1'b0};
                p_next[FB_C] = e.operand[7];
                p_next[FB_N] = r[7];
                p_next[FB_Z] = (r == 8'h00);
                res_next.write_valid   = 1'b1;
                res_next.write_address = e.wr_addr;
                res_next.write_data    = r;
            end
            K_BIT: begin
                p_next[FB_V] = e.operand[6];
                p_next[FB_N] = e.operand[7];
                p_next[FB_Z] = ((a_reg & e.operand) == 8'h00);
            end
            K_BRANCH: begin
                if (taken) begin
                    pc_next = tgt;
                    res_next.cycle_count = (pc_adv[15:8] != tgt[15:8]) ? 3'd4 : 3'd3;
                end
            end
            K_BRK: begin
                // Pushes: return high, return low, then P with B set
                p_next       = p_reg | (8'h01 << FB_I);
                pc_next      = brk_vec_reg;
                sp_next      = sp_reg - BRK_SP_DEC;
                final_beat   = (beat_reg == BEAT_LAST);
                res_next.write_valid   = 1'b1;
                res_next.write_address = {STACK_PAGE, sp_reg - {6'd0, beat_reg}};
                case (beat_reg)
                    2'd0:    res_next.write_data = pc_adv[15:8];
                    2'd1:    res_next.write_data = pc_adv[7:0];
                    default: res_next.write_data = p_reg | (8'h01 << FB_B);
                endcase
            end
            default: begin
                pc_next = pc_reg;
                res_next.cycle_count = 3'd0;
                res_next.illegal     = 1'b1;
            end
        endcase

        res_next.reg_a        = a_next;
        res_next.status       = p_next;
        res_next.prog_counter = pc_next;
        res_next.last         = final_beat;
    end

    // Architectural state, break vector and beat counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg       <= '0;
            p_reg       <= '0;
            pc_reg      <= '0;
            sp_reg      <= '0;
            brk_vec_reg <= '0;
            beat_reg    <= '0;
            valid_reg   <= 1'b0;
        end else begin
            if (fire) begin
                valid_reg <= 1'b1;
            end else if (res_ready) begin
                valid_reg <= 1'b0;
            end
            if (fire) begin
                if (final_beat) begin
                    a_reg    <= a_next;
                    p_reg    <= p_next;
                    pc_reg   <= pc_next;
                    sp_reg   <= sp_next;
                    beat_reg <= '0;
                end else begin
                    beat_reg <= beat_reg + 1'b1;
                end
            end
            // Config must only arrive while idle, which the block does not enforce; a reset vector write loads PC
            if (cfg_wr) begin
                case (cfg_idx)
                    CFG_RESET_VEC: pc_reg      <= cfg_wdata;
                    CFG_BREAK_VEC: brk_vec_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_next;
        end
    end

endmodule

FILE: design/cpu6502_alu_branch_execute_top.sv
// Top level of the 6502 ALU/branch execute block: front end, queue and
// back end. Uses c65ab_pkg, c65ab_front, c65ab_queue, c65ab_exec.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+---------------------------------------
//  s_      | in  | s_tvalid / s_tready | s_tdata, s_tuser (func, mode)
//  m_      | out | m_tvalid / m_tready | m_tdata, m_tlast
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One instruction per cycle sustained while m_tready is high; BRK gives three
// push beats, as the back end's single result register carries one beat a cycle.
// An input beat passes through the queue, then the result register, before it
// leaves as a result beat. The A/P/PC update in the back end sets the per-cycle
// limit. Reset is synchronous, active low: empties the queue and result register,
// clears A, P, SP, the break vector and PC. The queue lets the input keep
// flowing for QUEUE_DEPTH beats while m_tready is low.
module cpu6502_alu_branch_execute_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] operand, [23:8] base_address, [31:24] index
    input  logic [c65ab_pkg::S_TDATA_W-1:0]     s_tdata,
    // [3:0] func, [7:4] mode
    input  logic [c65ab_pkg::S_TUSER_W-1:0]     s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] reg_a, [15:8] status, [31:16] prog_counter, [34:32] cycle_count,
    // [35] write_valid, [51:36] write_address, [59:52] write_data,
    // [60] illegal, [63:61] zero
    output logic [c65ab_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                                m_tlast,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [c65ab_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                         cfg_data
);
    import c65ab_pkg::*;

    q_entry_t q_wdata, q_rdata;
    logic     q_wr, q_rd, q_full, q_empty;
    res_t     res;

    assign cfg_ready = 1'b1;

    c65ab_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_wr     (q_wr),
        .q_wdata  (q_wdata)
    );

    c65ab_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_wr),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    c65ab_exec u_exec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_rdata   (q_rdata),
        .q_rd      (q_rd),
        .cfg_wr    (cfg_valid),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Pack the result beat
    assign m_tdata = {3'b000, res.illegal, res.write_data, res.write_address,
                      res.write_valid, res.cycle_count, res.prog_counter,
                      res.status, res.reg_a};
    assign m_tlast = res.last;

endmodule

FILE: design/c65ab_checker.sv
// Port-level checker for the execute block's result stream, with its bind.
// Uses c65ab_pkg and cpu6502_alu_branch_execute_top_defines.svh.
`include "cpu6502_alu_branch_execute_top_defines.svh"

module c65ab_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [c65ab_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                            m_tlast
);
    import c65ab_pkg::*;

    // Stalled beat holds
    `C65AB_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result beat changed")

    // Illegal pair: single beat, no cycles, no write
    `C65AB_ASSERT_SAME(a_illegal, m_tvalid && m_tdata[OUT_ILL_BIT], m_tlast && (m_tdata[OUT_CYC_HI:OUT_CYC_LO] == 3'd0) && !m_tdata[OUT_WV_BIT], "illegal beat malformed")

    // Only BRK pushes are non-final, and they write with BRK's cycle_count
    `C65AB_ASSERT_SAME(a_push, m_tvalid && !m_tlast, m_tdata[OUT_WV_BIT] && (m_tdata[OUT_CYC_HI:OUT_CYC_LO] == 3'd7), "non-final beat is not a push")

    // Push beats of one BRK follow without a gap
    `C65AB_ASSERT_NEXT(a_burst, m_tvalid && m_tready && !m_tlast, m_tvalid, "gap inside BRK push burst")

endmodule

bind cpu6502_alu_branch_execute_top c65ab_checker u_c65ab_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
